// ===== rtl/display_pixel_format_packer_defines.svh =====
// assertion macros for the pixel format packer
`ifndef DISPLAY_PIXEL_FORMAT_PACKER_DEFINES_SVH
`define DISPLAY_PIXEL_FORMAT_PACKER_DEFINES_SVH

`ifndef ASSERT_OFF
`define DPFP_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
`define DPFP_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define DPFP_ASSERT_IMPL(label, clk, rst_n, pre, post, msg)
`define DPFP_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif

`endif

// ===== rtl/dpfp_pkg.sv =====
`default_nettype none
package dpfp_pkg;

    localparam logic [2:0] MODE_COPY    = 3'd0;
    localparam logic [2:0] MODE_SWAP16  = 3'd1;
    localparam logic [2:0] MODE_RGB444  = 3'd2;
    localparam logic [2:0] MODE_RGB332  = 3'd3;
    localparam logic [2:0] MODE_GRAY256 = 3'd4;
    localparam logic [2:0] MODE_GRAY16  = 3'd5;

    localparam logic [1:0] PHASE_FIRST  = 2'd0;
    localparam logic [1:0] PHASE_SECOND = 2'd1;
    localparam logic [1:0] PHASE_THIRD  = 2'd2;
    localparam logic [1:0] PHASE_FOURTH = 2'd3;

    // result bytes of one input word, first byte to send in the low bits
    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  count;
        logic        last_stream;
    } t_conv_out;

    typedef struct packed {
        logic [1:0] phase;
        logic [7:0] held_byte;
        logic [3:0] held_blue;
    } t_pack_state;

    function automatic logic [15:0] gray16_pixel(input logic [3:0] nib);
        logic [5:0] g6;
        logic [4:0] g5;
        g6 = {nib, nib[3:2]};
        g5 = g6[5:1];
        return {g5, g6, g5};
    endfunction

endpackage
`default_nettype wire

// ===== rtl/dpfp_convert.sv =====
`default_nettype none
module dpfp_convert (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wen,
    input  wire logic [2:0]        i_cfg_wdata,
    input  wire logic              i_accept,
    input  wire logic [7:0]        i_data,
    input  wire logic              i_last,
    output dpfp_pkg::t_conv_out    o_conv
);

    logic [2:0]            r_mode;
    dpfp_pkg::t_pack_state r_state;
    dpfp_pkg::t_pack_state n_state;
    dpfp_pkg::t_conv_out   n_conv;

    logic [15:0] w_pix;
    logic [15:0] w_pix_lo;
    logic [3:0]  w_r;
    logic [3:0]  w_g;
    logic [3:0]  w_b;

    always_comb begin
        w_r = i_data[7:4];
        w_g = {i_data[2:0], r_state.held_byte[7]};
        w_b = r_state.held_byte[4:1];
        w_pix = 16'h0000;
        w_pix_lo = 16'h0000;
        n_state = r_state;
        n_conv.data = 32'h0000_0000;
        n_conv.count = 3'd0;
        n_conv.last_stream = i_last;
        case (r_mode)
            dpfp_pkg::MODE_SWAP16: begin
                if (r_state.phase == dpfp_pkg::PHASE_FIRST) begin
                    if (i_last) begin
                        n_conv.data = {16'h0000, i_data, 8'h00};
                        n_conv.count = 3'd2;
                    end else begin
                        n_state.held_byte = i_data;
                        n_state.phase = dpfp_pkg::PHASE_SECOND;
                    end
                end else begin
                    n_conv.data = {16'h0000, r_state.held_byte, i_data};
                    n_conv.count = 3'd2;
                    n_state.phase = dpfp_pkg::PHASE_FIRST;
                end
            end
            dpfp_pkg::MODE_RGB444: begin
                case (r_state.phase)
                    dpfp_pkg::PHASE_FIRST, dpfp_pkg::PHASE_THIRD: begin
                        if (i_last && r_state.phase == dpfp_pkg::PHASE_THIRD) begin
                            n_conv.data = {24'h000000, r_state.held_blue, 4'h0};
                            n_conv.count = 3'd1;
                        end
                        n_state.held_byte = i_data;
                        n_state.phase = r_state.phase + 2'd1;
                    end
                    dpfp_pkg::PHASE_SECOND: begin
                        n_state.held_blue = w_b;
                        n_state.phase = dpfp_pkg::PHASE_THIRD;
                        if (i_last) begin
                            n_conv.data = {16'h0000, w_b, 4'h0, w_r, w_g};
                            n_conv.count = 3'd2;
                        end else begin
                            n_conv.data = {24'h000000, w_r, w_g};
                            n_conv.count = 3'd1;
                        end
                    end
                    default: begin
                        n_conv.data = {16'h0000, w_g, w_b, r_state.held_blue, w_r};
                        n_conv.count = 3'd2;
                        n_state.phase = dpfp_pkg::PHASE_FIRST;
                    end
                endcase
            end
            dpfp_pkg::MODE_RGB332: begin
                w_pix = {i_data[7:5], i_data[7:6], i_data[4:2], i_data[4:2],
                         i_data[1:0], i_data[1:0], i_data[1]};
                n_conv.data = {16'h0000, w_pix[7:0], w_pix[15:8]};
                n_conv.count = 3'd2;
                n_state.phase = dpfp_pkg::PHASE_FIRST;
            end
            dpfp_pkg::MODE_GRAY256: begin
                w_pix = {i_data[7:3], i_data[7:2], i_data[7:3]};
                n_conv.data = {16'h0000, w_pix[7:0], w_pix[15:8]};
                n_conv.count = 3'd2;
                n_state.phase = dpfp_pkg::PHASE_FIRST;
            end
            dpfp_pkg::MODE_GRAY16: begin
                w_pix = dpfp_pkg::gray16_pixel(i_data[7:4]);
                w_pix_lo = dpfp_pkg::gray16_pixel(i_data[3:0]);
                n_conv.data = {w_pix_lo[7:0], w_pix_lo[15:8], w_pix[7:0], w_pix[15:8]};
                n_conv.count = 3'd4;
                n_state.phase = dpfp_pkg::PHASE_FIRST;
            end
            default: begin
                n_conv.data = {24'h000000, i_data};
                n_conv.count = 3'd1;
                n_state.phase = dpfp_pkg::PHASE_FIRST;
            end
        endcase
        if (i_last) begin
            n_state = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= dpfp_pkg::MODE_COPY;
            r_state <= '0;
        end else if (i_cfg_wen) begin
            r_mode <= i_cfg_wdata;
            r_state <= '0;
        end else if (i_accept) begin
            r_state <= n_state;
        end
    end

    assign o_conv = n_conv;

endmodule
`default_nettype wire

// ===== rtl/dpfp_serializer.sv =====
`default_nettype none
module dpfp_serializer (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire dpfp_pkg::t_conv_out i_conv,
    output logic                   o_free,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [7:0]             o_byte,
    output logic                   o_last_item,
    output logic                   o_last_stream
);

    logic [31:0] r_data;
    logic [2:0]  r_cnt;
    logic        r_last_stream;
    logic        w_take;

    assign w_take = o_valid && i_ready;
    assign o_valid = (r_cnt != 3'd0);
    assign o_free = (r_cnt == 3'd0) || (r_cnt == 3'd1 && i_ready);
    assign o_byte = r_data[7:0];
    assign o_last_item = (r_cnt == 3'd1);
    assign o_last_stream = (r_cnt == 3'd1) && r_last_stream;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (i_load) begin
            r_cnt <= i_conv.count;
        end else if (w_take) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_conv.data;
            r_last_stream <= i_conv.last_stream;
        end else if (w_take) begin
            r_data <= {8'h00, r_data[31:8]};
        end
    end

endmodule
`default_nettype wire

// ===== rtl/display_pixel_format_packer.sv =====
`default_nettype none
`include "display_pixel_format_packer_defines.svh"
// Display pixel format packer: converts a source pixel byte stream into display bytes
// per format_mode (0 copy, 1 swap16, 2 rgb565le to rgb444, 3 rgb332, 4 gray256,
// 5 gray16 to rgb565be; 6 and 7 copy). Each input word is converted combinationally
// into zero to four result bytes held in an output buffer, which sends one byte per
// cycle on the master side while tready is high; tlast marks the final byte of a
// transfer and tuser[0] the final byte caused by one input word. A new input word is
// taken in the cycle the buffer hands off its last byte. An item's byte count is one
// in copy mode, up to two in swap16, rgb444, rgb332 and gray256, four in gray16.
// The single byte-wide output lane sets the rate. Writing format_mode drops any held
// partial word or pixel pair; write it only while the block is idle.
module display_pixel_format_packer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wen,
    input  wire logic [2:0]  i_cfg_wdata,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  wire logic        i_s_tlast,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata,   // [7:0] out_byte
    output logic [0:0]       o_m_tuser,   // [0] last_of_item
    output logic             o_m_tlast
);

    dpfp_pkg::t_conv_out w_conv;
    logic                w_accept;
    logic                w_free;
    logic                w_last_item;

    assign w_accept = i_s_tvalid && w_free;
    assign o_s_tready = w_free;
    assign o_m_tuser = w_last_item;

    dpfp_convert u_convert (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (w_accept),
        .i_data      (i_s_tdata),
        .i_last      (i_s_tlast),
        .o_conv      (w_conv)
    );

    dpfp_serializer u_serializer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_accept),
        .i_conv        (w_conv),
        .o_free        (w_free),
        .o_valid       (o_m_tvalid),
        .i_ready       (i_m_tready),
        .o_byte        (o_m_tdata),
        .o_last_item   (w_last_item),
        .o_last_stream (o_m_tlast)
    );

    `DPFP_ASSERT_IMPL(a_ready_when_empty, i_clk, i_rst_n, !o_m_tvalid, o_s_tready, "ready low with empty output buffer")
    `DPFP_ASSERT_IMPL(a_tlast_ends_item, i_clk, i_rst_n, o_m_tvalid && o_m_tlast, o_m_tuser[0], "tlast without last_of_item")
    `DPFP_ASSERT_NEXT(a_item_continues, i_clk, i_rst_n, o_m_tvalid && i_m_tready && !o_m_tuser[0], o_m_tvalid, "bytes of a word lost")

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

typedef struct {
    logic [7:0] pix;
    logic       item_end;
    logic       stream_end;
} t_pack_byte;

class packer_scoreboard;
    logic [2:0] mode;
    logic [1:0] phase;
    logic [7:0] held;
    logic [3:0] held_blue;
    t_pack_byte pending_bytes[$];
    int errors;
    int words_seen;
    int bytes_checked;

    function new();
        mode = dpfp_pkg::MODE_COPY;
        phase = dpfp_pkg::PHASE_FIRST;
        held = 8'h00;
        held_blue = 4'h0;
        errors = 0;
        words_seen = 0;
        bytes_checked = 0;
    endfunction

    function void set_mode(logic [2:0] m);
        mode = m;
        phase = dpfp_pkg::PHASE_FIRST;
        held = 8'h00;
        held_blue = 4'h0;
    endfunction

    function int pending();
        return pending_bytes.size();
    endfunction

    function logic [15:0] gray_nibble(logic [3:0] n);
        logic [5:0] g6;
        g6 = {n, n[3:2]};
        return {g6[5:1], g6, g6[5:1]};
    endfunction

    // converts one source word into the bytes it sends
    function void convert_word(logic [7:0] v, logic l);
        logic [7:0]  outs[$];
        logic [15:0] p;
        logic [3:0]  r4;
        logic [3:0]  g4;
        logic [3:0]  b4;
        logic [2:0]  r3;
        logic [2:0]  g3;
        logic [1:0]  b2;
        t_pack_byte  e;
        words_seen++;
        case (mode)
            dpfp_pkg::MODE_SWAP16: begin
                if (phase == dpfp_pkg::PHASE_FIRST) begin
                    if (l) begin
                        outs.push_back(8'h00);
                        outs.push_back(v);
                    end else begin
                        held = v;
                        phase = dpfp_pkg::PHASE_SECOND;
                    end
                end else begin
                    outs.push_back(v);
                    outs.push_back(held);
                    phase = dpfp_pkg::PHASE_FIRST;
                end
            end
            dpfp_pkg::MODE_RGB444: begin
                if (phase == dpfp_pkg::PHASE_FIRST || phase == dpfp_pkg::PHASE_THIRD) begin
                    if (l && phase == dpfp_pkg::PHASE_THIRD)
                        outs.push_back({held_blue, 4'h0});
                    held = v;
                    phase = phase + 2'd1;
                end else begin
                    p = {v, held};
                    r4 = p[15:12];
                    g4 = p[10:7];
                    b4 = p[4:1];
                    if (phase == dpfp_pkg::PHASE_SECOND) begin
                        outs.push_back({r4, g4});
                        held_blue = b4;
                        phase = dpfp_pkg::PHASE_THIRD;
                        if (l)
                            outs.push_back({b4, 4'h0});
                    end else begin
                        outs.push_back({held_blue, r4});
                        outs.push_back({g4, b4});
                        phase = dpfp_pkg::PHASE_FIRST;
                    end
                end
            end
            dpfp_pkg::MODE_RGB332: begin
                r3 = v[7:5];
                g3 = v[4:2];
                b2 = v[1:0];
                p = {r3, r3[2:1], g3, g3, b2, b2, b2[1]};
                outs.push_back(p[15:8]);
                outs.push_back(p[7:0]);
                phase = dpfp_pkg::PHASE_FIRST;
            end
            dpfp_pkg::MODE_GRAY256: begin
                p = {v[7:3], v[7:2], v[7:3]};
                outs.push_back(p[15:8]);
                outs.push_back(p[7:0]);
                phase = dpfp_pkg::PHASE_FIRST;
            end
            dpfp_pkg::MODE_GRAY16: begin
                p = gray_nibble(v[7:4]);
                outs.push_back(p[15:8]);
                outs.push_back(p[7:0]);
                p = gray_nibble(v[3:0]);
                outs.push_back(p[15:8]);
                outs.push_back(p[7:0]);
                phase = dpfp_pkg::PHASE_FIRST;
            end
            default: begin
                outs.push_back(v);
                phase = dpfp_pkg::PHASE_FIRST;
            end
        endcase
        if (l) begin
            phase = dpfp_pkg::PHASE_FIRST;
            held = 8'h00;
            held_blue = 4'h0;
        end
        foreach (outs[i]) begin
            e.pix = outs[i];
            e.item_end = (i == outs.size() - 1);
            e.stream_end = e.item_end && l;
            pending_bytes.push_back(e);
        end
    endfunction

    task report(string msg);
        $display("ERROR: %s", msg);
        errors++;
    endtask

    task check_byte(logic [7:0] b, logic ie, logic se);
        t_pack_byte e;
        if (pending_bytes.size() == 0) begin
            report($sformatf("unexpected byte %02h item_end %b stream_end %b", b, ie, se));
            return;
        end
        e = pending_bytes.pop_front();
        bytes_checked++;
        if ({b, ie, se} !== {e.pix, e.item_end, e.stream_end})
            report($sformatf("byte %0d: got %02h/%b/%b, want %02h/%b/%b", bytes_checked,
                b, ie, se, e.pix, e.item_end, e.stream_end));
    endtask
endclass

module testbench;
    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;
    localparam int CYCLE_LIMIT = 500000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_wen = 1'b0;
    logic [2:0] i_cfg_wdata = 3'd0;
    logic       i_s_tvalid = 1'b0;
    logic [7:0] i_s_tdata = 8'h00;
    logic       i_s_tlast = 1'b0;
    logic       i_m_tready = 1'b0;
    logic       o_s_tready;
    logic       o_m_tvalid;
    logic [7:0] o_m_tdata;
    logic [0:0] o_m_tuser;
    logic       o_m_tlast;

    packer_scoreboard board;
    bit idle_on = 1'b1;
    int stall_left = 0;
    int cycles = 0;
    int words_sent = 0;
    int mode_writes = 0;

    display_pixel_format_packer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("display_pixel_format_packer: mismatch");
            $finish;
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= (stall_left == 1);
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(1, 17);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_wen)
                board.set_mode(i_cfg_wdata);
            if (i_s_tvalid && o_s_tready)
                board.convert_word(i_s_tdata, i_s_tlast);
            if (o_m_tvalid && i_m_tready)
                board.check_byte(o_m_tdata, o_m_tuser[0], o_m_tlast);
        end
    end

    task automatic send_word(input logic [7:0] d, input logic l);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= d;
        i_s_tlast <= l;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic write_mode(input logic [2:0] m);
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_wen <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        mode_writes++;
    endtask

    task automatic run_phase(input logic [2:0] m, input int count, input bit close);
        logic [7:0] d;
        logic       l;
        write_mode(m);
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(0, 9))
                0: d = 8'h00;
                1: d = 8'hFF;
                default: d = 8'($urandom_range(0, 255));
            endcase
            l = ($urandom_range(0, 7) == 0) || (close && k == count - 1);
            send_word(d, l);
        end
    endtask

    initial begin
        logic [2:0] m;
        board = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_mode(dpfp_pkg::MODE_COPY);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b1);
        write_mode(MODE_SPARE6);
        send_word(8'hA5, 1'b1);
        write_mode(MODE_SPARE7);
        send_word(8'h5A, 1'b0);
        // lone byte at the end goes out with a zero partner
        write_mode(dpfp_pkg::MODE_SWAP16);
        send_word(8'h12, 1'b0);
        send_word(8'h34, 1'b0);
        send_word(8'hAB, 1'b1);
        // full pair, finished first pixel, unfinished second, lone dropped byte
        write_mode(dpfp_pkg::MODE_RGB444);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h34, 1'b0);
        send_word(8'h12, 1'b1);
        send_word(8'h56, 1'b0);
        send_word(8'h78, 1'b0);
        send_word(8'h9A, 1'b1);
        send_word(8'hCD, 1'b1);
        write_mode(dpfp_pkg::MODE_RGB332);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h6D, 1'b1);
        write_mode(dpfp_pkg::MODE_GRAY256);
        send_word(8'hFF, 1'b0);
        send_word(8'h80, 1'b1);
        write_mode(dpfp_pkg::MODE_GRAY16);
        send_word(8'hF0, 1'b0);
        send_word(8'h0F, 1'b1);
        // held byte dropped by the mode write
        write_mode(dpfp_pkg::MODE_SWAP16);
        send_word(8'h77, 1'b0);

        for (int ph = 0; ph < 14; ph++) begin
            if (ph < 8)
                m = ph[2:0];
            else if ($urandom_range(0, 3) == 0)
                m = 3'($urandom_range(6, 7));
            else
                m = 3'($urandom_range(0, 5));
            idle_on = (ph < 12) && (ph != 5);
            run_phase(m, 30, 1'($urandom_range(0, 1)));
        end

        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("sent %0d source words over %0d mode writes, all six modes and both spares",
            words_sent, mode_writes);
        $display("checked %0d display bytes, %0d errors", board.bytes_checked, board.errors);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("display_pixel_format_packer: match");
        end else begin
            $display("display_pixel_format_packer: mismatch");
        end
        $finish;
    end
endmodule
